@@ hw/rtl/ihx_enc_pkg.sv @@
// Shared types, character constants and helper functions for the Intel HEX encoder.
// Depends on nothing; every other file of the encoder imports it.
`timescale 1ns / 1ps
`default_nettype none

package ihx_enc_pkg;

   // Kept-byte buffer and record limits
   localparam int MaxRecordBytes = 16;
   localparam int CountWidth     = 5;
   localparam int AddrWidth      = 16;
   localparam int IdxWidth       = 6;
   localparam int EndTextLen     = 12;

   // Selection modes
   localparam logic [1:0] ModeAll  = 2'd0;
   localparam logic [1:0] ModeEven = 2'd1;
   localparam logic [1:0] ModeOdd  = 2'd2;

   // Fixed characters
   localparam logic [7:0] CharColon   = 8'h3a;
   localparam logic [7:0] CharZero    = 8'h30;
   localparam logic [7:0] CharNewline = 8'h0a;

   // Character positions inside a data record before the payload
   localparam logic [IdxWidth-1:0] IdxColon    = IdxWidth'(0);
   localparam logic [IdxWidth-1:0] IdxCountHi  = IdxWidth'(1);
   localparam logic [IdxWidth-1:0] IdxCountLo  = IdxWidth'(2);
   localparam logic [IdxWidth-1:0] IdxAddr3    = IdxWidth'(3);
   localparam logic [IdxWidth-1:0] IdxAddr2    = IdxWidth'(4);
   localparam logic [IdxWidth-1:0] IdxAddr1    = IdxWidth'(5);
   localparam logic [IdxWidth-1:0] IdxAddr0    = IdxWidth'(6);
   localparam logic [IdxWidth-1:0] IdxTypeHi   = IdxWidth'(7);
   localparam logic [IdxWidth-1:0] IdxTypeLo   = IdxWidth'(8);
   localparam logic [IdxWidth-1:0] IdxPayload  = IdxWidth'(9);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_of_run;
   } rsp_type;

   // One job for the back end: an optional data record, then an optional end record
   typedef struct packed {
      logic                                has_record;
      logic                                is_end;
      logic [CountWidth-1:0]               count;
      logic [AddrWidth-1:0]                addr;
      logic [MaxRecordBytes-1:0][7:0]      data;
   } cmd_type;

   typedef enum logic [1:0] {
      BackIdle,
      BackRecord,
      BackEnd
   } back_state_type;

   // Lowercase hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h57 + {4'd0, nib};
      end
      return ch;
   endfunction

   // Characters of the end-of-file record ":00000001FF\n"
   function automatic logic [7:0] end_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = CharColon;
         4'd8:    ch = 8'h31;
         4'd9:    ch = 8'h46;
         4'd10:   ch = 8'h46;
         4'd11:   ch = CharNewline;
         default: ch = CharZero;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ihx_front.sv @@
// Front end of the Intel HEX encoder: takes bytes, keeps them by mode, builds jobs.
// Depends on ihx_enc_pkg; feeds ihx_cmd_fifo.
`timescale 1ns / 1ps
`default_nettype none

module ihx_front #(
   parameter int RECORD_BYTES = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_push,
   output logic                  req_full,
   input  ihx_enc_pkg::req_type  req_data,
   input  wire                   csr_we,
   input  wire [1:0]             csr_wdata,
   output logic                  cmd_push,
   output ihx_enc_pkg::cmd_type  cmd_wdata,
   input  wire                   cmd_full
);
   import ihx_enc_pkg::*;

   localparam int PosWidth = $clog2(RECORD_BYTES + 1);

   logic [1:0]                     mode_ff, mode_in;
   logic                           parity_ff, parity_in;
   logic [PosWidth-1:0]            pos_ff, pos_in, pos_next;
   logic [CountWidth-1:0]          count_ff, count_in, count_next;
   logic [AddrWidth-1:0]           addr_ff, addr_in;
   logic [MaxRecordBytes-1:0][7:0] kept_ff, kept_in;
   logic                           accept, keep;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   // Classify the request and update the block state
   always_comb begin
      mode_in   = csr_we ? csr_wdata : mode_ff;
      parity_in = parity_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;
      kept_in   = kept_ff;
      cmd_push  = 1'b0;
      case (mode_ff)
         ModeEven: keep = !parity_ff;
         ModeOdd:  keep = parity_ff;
         default:  keep = 1'b1;
      endcase
      pos_next   = pos_ff + PosWidth'(1);
      count_next = count_ff;
      if (keep && !req_data.end_of_data && count_ff < CountWidth'(MaxRecordBytes)) begin
         kept_in[count_ff[3:0]] = req_data.data_byte;
         count_next = count_ff + CountWidth'(1);
      end
      cmd_wdata.has_record = 1'b1;
      cmd_wdata.is_end     = req_data.end_of_data;
      cmd_wdata.count      = count_next;
      cmd_wdata.addr       = addr_ff;
      cmd_wdata.data       = kept_in;
      if (accept) begin
         if (req_data.end_of_data) begin
            // flush the partial block and restart the image
            cmd_push             = 1'b1;
            cmd_wdata.has_record = (pos_ff != '0);
            parity_in            = 1'b0;
            pos_in               = '0;
            count_in             = '0;
            addr_in              = '0;
         end else begin
            parity_in = !parity_ff;
            if (pos_next == PosWidth'(RECORD_BYTES)) begin
               cmd_push = 1'b1;
               pos_in   = '0;
               count_in = '0;
               addr_in  = addr_ff + AddrWidth'(count_next);
            end else begin
               pos_in   = pos_next;
               count_in = count_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ModeAll;
         parity_ff <= 1'b0;
         pos_ff    <= '0;
         count_ff  <= '0;
         addr_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         parity_ff <= parity_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         addr_ff   <= addr_in;
      end
   end

   // Kept bytes need no reset: only entries below the count are read
   always_ff @(posedge clock) begin
      if (accept) begin
         kept_ff <= kept_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/ihx_cmd_fifo.sv @@
// Short job queue between the front and back ends of the Intel HEX encoder.
// Depends on ihx_enc_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module ihx_cmd_fifo #(
   parameter int DEPTH = 2
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  ihx_enc_pkg::cmd_type  wdata,
   output logic                  full,
   input  wire                   pop,
   output ihx_enc_pkg::cmd_type  rdata,
   output logic                  empty
);
   import ihx_enc_pkg::*;

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);

   cmd_type               entry_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == CntWidth'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   // Advance the pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/ihx_back.sv @@
// Back end of the Intel HEX encoder: jobs into text, one character a cycle when popped.
// Depends on ihx_enc_pkg; reads ihx_cmd_fifo and drives the result queue ports.
`timescale 1ns / 1ps
`default_nettype none

module ihx_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   cmd_empty,
   input  ihx_enc_pkg::cmd_type  cmd_rdata,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  wire                   rsp_pop,
   output ihx_enc_pkg::rsp_type  rsp_data
);
   import ihx_enc_pkg::*;

   back_state_type        state_ff, state_in;
   logic [IdxWidth-1:0]   idx_ff, idx_in, offs, pay_end;
   logic [7:0]            sum_ff, sum_in, chk, cur_byte;
   cmd_type               cmd_ff, cmd_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;
   logic                  adv, emit, last;
   logic [7:0]            ch;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign adv       = !out_valid_ff || rsp_pop;
   assign offs      = idx_ff - IdxPayload;
   assign pay_end   = {cmd_ff.count, 1'b0};
   assign cur_byte  = cmd_ff.data[offs[4:1]];
   assign chk       = 8'(~sum_ff + 8'd1);

   // Sequence the characters of each job
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      cmd_in   = cmd_ff;
      cmd_pop  = 1'b0;
      emit     = 1'b0;
      last     = 1'b0;
      ch       = CharZero;
      case (state_ff)
         BackIdle: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_rdata;
               idx_in   = '0;
               sum_in   = 8'({3'd0, cmd_rdata.count}) + cmd_rdata.addr[7:0]
                          + cmd_rdata.addr[15:8];
               state_in = cmd_rdata.has_record ? BackRecord : BackEnd;
            end
         end
         BackRecord: begin
            if (adv) begin
               emit   = 1'b1;
               idx_in = idx_ff + IdxWidth'(1);
               case (idx_ff)
                  IdxColon:   ch = CharColon;
                  IdxCountHi: ch = hex_char({3'd0, cmd_ff.count[4]});
                  IdxCountLo: ch = hex_char(cmd_ff.count[3:0]);
                  IdxAddr3:   ch = hex_char(cmd_ff.addr[15:12]);
                  IdxAddr2:   ch = hex_char(cmd_ff.addr[11:8]);
                  IdxAddr1:   ch = hex_char(cmd_ff.addr[7:4]);
                  IdxAddr0:   ch = hex_char(cmd_ff.addr[3:0]);
                  IdxTypeHi:  ch = CharZero;
                  IdxTypeLo:  ch = CharZero;
                  default: begin
                     if (offs < pay_end) begin
                        // data bytes, high nibble first; add to the sum on the low one
                        if (offs[0]) begin
                           ch     = hex_char(cur_byte[3:0]);
                           sum_in = sum_ff + cur_byte;
                        end else begin
                           ch = hex_char(cur_byte[7:4]);
                        end
                     end else if (offs == pay_end) begin
                        ch = hex_char(chk[7:4]);
                     end else if (offs == pay_end + IdxWidth'(1)) begin
                        ch = hex_char(chk[3:0]);
                     end else begin
                        ch       = CharNewline;
                        last     = !cmd_ff.is_end;
                        idx_in   = '0;
                        state_in = cmd_ff.is_end ? BackEnd : BackIdle;
                     end
                  end
               endcase
            end
         end
         BackEnd: begin
            if (adv) begin
               emit   = 1'b1;
               ch     = end_char(idx_ff[3:0]);
               idx_in = idx_ff + IdxWidth'(1);
               if (idx_ff == IdxWidth'(EndTextLen - 1)) begin
                  last     = 1'b1;
                  idx_in   = '0;
                  state_in = BackIdle;
               end
            end
         end
         default: state_in = BackIdle;
      endcase
   end

   // Output register: load on emit, drop on pop
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in       = 1'b1;
         out_in.text_char   = ch;
         out_in.last_of_run = last;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BackIdle;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      cmd_ff <= cmd_in;
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/intel_hex_record_encoder.sv @@
// Top level of the Intel HEX encoder: front end, job queue and back end.
// Depends on ihx_enc_pkg, ihx_front, ihx_cmd_fifo and ihx_back.
//
// Usage:
//  - Request side: drive req_data and raise req_push; a request is taken on a
//    clock edge where req_push is high and req_full is low. Each byte request
//    fills one of the RECORD_BYTES positions of a block; end_of_data flushes the
//    partial block and adds the end-of-file record.
//  - Result side: while rsp_empty is low, rsp_data holds the oldest character;
//    it is taken on an edge with rsp_pop high. last_of_run marks the final
//    character caused by one request.
//  - csr_we writes csr_wdata into the selection mode; write only while idle.
//  - The front end takes a byte request every clock while req_full is low. A
//    data record with n kept bytes leaves the back end as 12 + 2n characters
//    at one per cycle while rsp_pop keeps up, after its job is loaded; the end
//    record adds 12 characters, and a job load of its own only when no data
//    record comes before it. The back end's character sequencer sets the
//    sustained rate. With the back end idle, the first character passes the
//    job queue, the job register and the output register to the result ports.
//  - Reset clears mode, block state, address, the job queue and the output.
//  - If rsp_pop stays low the output register holds, the back end halts, the
//    job queue fills and req_full rises.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_encoder #(
   parameter int RECORD_BYTES = 16,
   parameter int CMD_DEPTH    = 2
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_push,
   output logic                  req_full,
   input  ihx_enc_pkg::req_type  req_data,
   output logic                  rsp_empty,
   input  wire                   rsp_pop,
   output ihx_enc_pkg::rsp_type  rsp_data,
   input  wire                   csr_we,
   input  wire [1:0]             csr_wdata
);
   import ihx_enc_pkg::*;

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_wdata, cmd_rdata;

   ihx_front #(
      .RECORD_BYTES (RECORD_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_push  (cmd_push),
      .cmd_wdata (cmd_wdata),
      .cmd_full  (cmd_full)
   );

   ihx_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   ihx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_rdata (cmd_rdata),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Every run of characters ends in a newline
   a_last_is_newline: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.last_of_run) |-> (rsp_data.text_char == CharNewline))
      else $error("run ended on a character other than newline");

   // The front end never pushes a job into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("job pushed into full queue");

   // A job is taken only when one is waiting
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("job taken from empty queue");

   // Output is empty straight after reset
   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> rsp_empty)
      else $error("result waiting right after reset");

endmodule

`default_nettype wire

@@ bench/ihx_text_checker.sv @@
// Checker for the Intel HEX encoder: watches the request, result and mode ports,
// predicts the hex text of every request and compares it with what the encoder pops.
// Depends on ihx_enc_pkg for the port payload types, modes and fixed characters.
`timescale 1ns / 1ps

module ihx_text_checker #(
   parameter int RecordBytes = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_push,
   input  wire                   req_full,
   input  ihx_enc_pkg::req_type  req_data,
   input  wire                   rsp_empty,
   input  wire                   rsp_pop,
   input  ihx_enc_pkg::rsp_type  rsp_data,
   input  wire                   csr_we,
   input  wire [1:0]             csr_wdata,
   output int                    fail_count,
   output int                    pending_chars
);
   import ihx_enc_pkg::*;

   // End-of-file record, first character in the top byte
   localparam logic [8*EndTextLen-1:0] EndRecordText = ":00000001FF\n";

   // Shadow of the encoder's block state
   logic [7:0]            kept_data [MaxRecordBytes];
   logic [4:0]            block_pos = '0;
   logic [4:0]            kept_cnt = '0;
   logic [AddrWidth-1:0]  load_addr = '0;
   logic                  odd_position = 1'b0;
   logic [1:0]            sel_mode = ModeAll;

   // Characters of the request being predicted, then the text still owed
   rsp_type               run_text [$];
   rsp_type               expected_text [$];
   rsp_type               want;
   int                    errors = 0;

   initial begin
      fail_count = 0;
      pending_chars = 0;
   end

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib > 4'd9) begin
         ch = "a" + 8'(nib - 4'd10);
      end else begin
         ch = "0" + 8'(nib);
      end
      return ch;
   endfunction

   task automatic put_char(input logic [7:0] ch);
      rsp_type r;
      r.text_char = ch;
      r.last_of_run = 1'b0;
      run_text.push_back(r);
   endtask

   task automatic put_hex(input logic [7:0] v);
      put_char(hex_digit(v[7:4]));
      put_char(hex_digit(v[3:0]));
   endtask

   // Emit one data record from the kept bytes and advance the load address
   task automatic close_record();
      logic [7:0] sum;
      sum = 8'(kept_cnt) + load_addr[7:0] + load_addr[15:8];
      put_char(CharColon);
      put_hex(8'(kept_cnt));
      put_hex(load_addr[15:8]);
      put_hex(load_addr[7:0]);
      put_hex(8'h00);
      for (int i = 0; i < int'(kept_cnt); i++) begin
         put_hex(kept_data[i]);
         sum = sum + kept_data[i];
      end
      put_hex(8'h00 - sum);
      put_char(CharNewline);
      load_addr = load_addr + AddrWidth'(kept_cnt);
      block_pos = '0;
      kept_cnt = '0;
   endtask

   // Work out the text one request causes and queue it, flagging its last character
   task automatic encode_request(input req_type r);
      logic    take;
      rsp_type c;
      run_text.delete();
      if (r.end_of_data) begin
         if (block_pos != 0) begin
            close_record();
         end
         for (int i = 0; i < EndTextLen; i++) begin
            put_char(EndRecordText[8*(EndTextLen-1-i) +: 8]);
         end
         block_pos = '0;
         kept_cnt = '0;
         load_addr = '0;
         odd_position = 1'b0;
      end else begin
         case (sel_mode)
            ModeEven: begin
               take = !odd_position;
            end
            ModeOdd: begin
               take = odd_position;
            end
            default: begin
               take = 1'b1;
            end
         endcase
         if (take && kept_cnt < MaxRecordBytes) begin
            kept_data[kept_cnt[3:0]] = r.data_byte;
            kept_cnt = kept_cnt + 5'd1;
         end
         odd_position = !odd_position;
         block_pos = block_pos + 5'd1;
         if (block_pos >= RecordBytes) begin
            close_record();
         end
      end
      foreach (run_text[i]) begin
         c = run_text[i];
         c.last_of_run = (i == run_text.size() - 1);
         expected_text.push_back(c);
      end
   endtask

   // Track mode writes, check popped characters, predict accepted requests
   always @(posedge clock) begin
      if (reset) begin
         expected_text.delete();
         block_pos = '0;
         kept_cnt = '0;
         load_addr = '0;
         odd_position = 1'b0;
         sel_mode = ModeAll;
      end else begin
         if (csr_we) begin
            sel_mode = csr_wdata;
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_text.size() == 0) begin
               errors++;
               $error("unexpected result: text_char %h, last_of_run %b",
                      rsp_data.text_char, rsp_data.last_of_run);
            end else begin
               want = expected_text.pop_front();
               if (rsp_data.text_char !== want.text_char) begin
                  errors++;
                  $error("text_char: expected %h, actual %h",
                         want.text_char, rsp_data.text_char);
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  errors++;
                  $error("last_of_run: expected %b, actual %b",
                         want.last_of_run, rsp_data.last_of_run);
               end
            end
         end
         if (req_push && !req_full) begin
            encode_request(req_data);
         end
      end
      pending_chars <= expected_text.size();
      fail_count <= errors;
   end

endmodule

@@ bench/intel_hex_record_encoder_tb.sv @@
// Top of the Intel HEX encoder bench: clock, reset, request and mode stimulus, verdict.
// Depends on ihx_enc_pkg, intel_hex_record_encoder and ihx_text_checker.
`timescale 1ns / 1ps

module intel_hex_record_encoder_tb;
   import ihx_enc_pkg::*;

   localparam int         RecordBytes = 16;
   localparam int         CycleLimit = 1_500_000;
   localparam int         DrainCycles = 16;
   localparam logic [1:0] ModeSpare = 2'd3;
   // One full block of extreme and alternating bytes
   localparam logic [8*16-1:0] FullBlock = 128'h00ff01807f55aa0ff010203cc39966fe;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   req_type    req_data = '0;
   logic       rsp_pop = 1'b0;
   logic       csr_we = 1'b0;
   logic [1:0] csr_wdata = ModeAll;
   logic       req_full;
   logic       rsp_empty;
   rsp_type    rsp_data;

   int send_gap_pct = 0;
   int pop_gap_pct = 0;
   int cycle_count = 0;
   int fail_count;
   int pending_chars;

   always #2 clock = ~clock;

   intel_hex_record_encoder #(
      .RECORD_BYTES(RecordBytes)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   ihx_text_checker #(
      .RecordBytes(RecordBytes)
   ) text_check (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_chars (pending_chars)
   );

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_gap_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one request after a random gap and hold it until taken
   task automatic send_request(input logic end_of_data, input logic [7:0] data_byte);
      req_type r;
      r.data_byte = data_byte;
      r.end_of_data = end_of_data;
      while ($urandom_range(99) < send_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
   endtask

   // Stop requests, wait for every owed character, then let the pipeline settle
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_chars != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly byte runs with the odd end request, random content throughout
   task automatic random_run(input int count, input logic [1:0] mode,
                             input int send_gap, input int pop_gap);
      write_mode(mode);
      send_gap_pct = send_gap;
      pop_gap_pct <= pop_gap;
      repeat (count) begin
         send_request($urandom_range(24) == 0, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      write_mode(ModeAll);

      // End request on a block boundary: end record only, byte ignored
      send_request(1'b1, 8'hff);
      // Full block of extreme bytes
      for (int i = 0; i < 16; i++) begin
         send_request(1'b0, FullBlock[8*(15-i) +: 8]);
      end
      // Partial block flushed by an end request
      send_request(1'b0, 8'hff);
      send_request(1'b0, 8'h00);
      send_request(1'b0, 8'h12);
      send_request(1'b1, 8'h00);
      // Odd positions only, one even byte: record with count zero
      write_mode(ModeOdd);
      send_request(1'b0, 8'hab);
      send_request(1'b1, 8'h5a);
      // Even positions only, short block
      write_mode(ModeEven);
      send_request(1'b0, 8'hc3);
      send_request(1'b0, 8'h3c);
      send_request(1'b1, 8'h00);

      random_run(80, ModeEven, 22, 66);
      random_run(80, ModeOdd, 66, 22);
      random_run(42, ModeSpare, 0, 0);
      random_run(42, ModeAll, 0, 0);

      drain();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
